FILE: hdl/btm_pkg.sv
package btm_pkg;

    localparam int CODE_DEPTH  = 4096;
    localparam int TAPE_DEPTH  = 4096;
    localparam int STACK_DEPTH = 64;
    localparam int CELL_BITS   = 32;

    localparam int CODE_AW  = $clog2(CODE_DEPTH);
    localparam int TAPE_AW  = $clog2(TAPE_DEPTH);
    localparam int STACK_AW = $clog2(STACK_DEPTH);
    localparam int PC_W     = 13;
    localparam int LEN_W    = 13;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_STEP    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_EXEC    = 4'd0,
        ST_OUT     = 4'd1,
        ST_WAIT    = 4'd2,
        ST_HALT    = 4'd3,
        ST_UNDER   = 4'd4,
        ST_UNCLOSE = 4'd5,
        ST_UNOPEN  = 4'd6,
        ST_STACK   = 4'd7,
        ST_TAPE    = 4'd8
    } status_t;

    localparam logic [7:0] OP_RIGHT = 8'h3E;
    localparam logic [7:0] OP_LEFT  = 8'h3C;
    localparam logic [7:0] OP_INC   = 8'h2B;
    localparam logic [7:0] OP_DEC   = 8'h2D;
    localparam logic [7:0] OP_OUT   = 8'h2E;
    localparam logic [7:0] OP_IN    = 8'h2C;
    localparam logic [7:0] OP_OPEN  = 8'h5B;
    localparam logic [7:0] OP_CLOSE = 8'h5D;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_FETCH,
        S_DECODE,
        S_SKIP_RD,
        S_SKIP_CHK,
        S_POP_RD,
        S_POP_USE,
        S_DONE
    } state_t;

    // Result of one step, handed to the output stage.
    typedef struct packed {
        status_t         status;
        logic [7:0]      out_byte;
        logic [PC_W-1:0] pc;
    } result_t;

endpackage

FILE: hdl/btm_ram.sv
module btm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/btm_seq.sv
module btm_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [1:0]                       cmd,
    input  logic [btm_pkg::CODE_AW-1:0]      code_address,
    input  logic [7:0]                       code_byte,
    input  logic                             input_valid,
    input  logic [7:0]                       input_byte,
    input  logic [btm_pkg::LEN_W-1:0]        program_length,
    output logic                             busy,
    output logic                             res_valid,
    output btm_pkg::result_t                 res
);

    localparam int CW = btm_pkg::CODE_AW;
    localparam int TW = btm_pkg::TAPE_AW;
    localparam int SW = btm_pkg::STACK_AW;
    localparam int PW = btm_pkg::PC_W;

    btm_pkg::state_t state_reg, state_next;
    logic [PW-1:0]   pc_reg, pc_next;
    logic [TW-1:0]   cell_idx_reg, cell_idx_next;
    logic [SW:0]     depth_reg, depth_next;
    btm_pkg::status_t stop_reg, stop_next;
    logic [PW-1:0]   scan_reg, scan_next;
    logic [PW-1:0]   nest_reg, nest_next;
    logic [TW:0]     clr_reg, clr_next;
    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    btm_pkg::result_t res_reg, res_next;
    logic            res_valid_reg, res_valid_next;

    logic [PW-1:0]   len;
    logic            code_we;
    logic [CW-1:0]   code_raddr;
    logic [7:0]      code_rdata;
    logic            tape_we;
    logic [TW-1:0]   tape_waddr;
    logic [btm_pkg::CELL_BITS-1:0] tape_wdata, tape_rdata;
    logic            stack_we;
    logic [SW-1:0]   stack_waddr, stack_raddr;
    logic [CW-1:0]   stack_wdata, stack_rdata;
    logic            cell_zero;

    assign len = (program_length > PW'(btm_pkg::CODE_DEPTH)) ?
                 PW'(btm_pkg::CODE_DEPTH) : program_length;
    assign cell_zero = (tape_rdata == '0);

    btm_ram #(.DEPTH(btm_pkg::CODE_DEPTH), .WIDTH(8)) u_code (
        .clk(clk), .we(code_we), .waddr(code_address), .wdata(code_byte),
        .raddr(code_raddr), .rdata(code_rdata)
    );

    btm_ram #(.DEPTH(btm_pkg::TAPE_DEPTH), .WIDTH(btm_pkg::CELL_BITS)) u_tape (
        .clk(clk), .we(tape_we), .waddr(tape_waddr), .wdata(tape_wdata),
        .raddr(cell_idx_reg), .rdata(tape_rdata)
    );

    btm_ram #(.DEPTH(btm_pkg::STACK_DEPTH), .WIDTH(CW)) u_stack (
        .clk(clk), .we(stack_we), .waddr(stack_waddr), .wdata(stack_wdata),
        .raddr(stack_raddr), .rdata(stack_rdata)
    );

    // State and machine registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= btm_pkg::S_CLEAR;
            pc_reg        <= '0;
            cell_idx_reg  <= '0;
            depth_reg     <= '0;
            stop_reg      <= btm_pkg::ST_EXEC;
            scan_reg      <= '0;
            nest_reg      <= '0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            cell_idx_reg  <= cell_idx_next;
            depth_reg     <= depth_next;
            stop_reg      <= stop_next;
            scan_reg      <= scan_next;
            nest_reg      <= nest_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Captured input and result payload.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            in_valid_reg <= input_valid;
            in_byte_reg  <= input_byte;
        end
        res_reg <= res_next;
    end

    // Sequencer: code load, tape clear, fetch, decode with one tape read-modify-write, bracket scan, stack pop.
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        cell_idx_next  = cell_idx_reg;
        depth_next     = depth_reg;
        stop_next      = stop_reg;
        scan_next      = scan_reg;
        nest_next      = nest_reg;
        clr_next       = clr_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        code_we        = 1'b0;
        code_raddr     = pc_reg[CW-1:0];
        tape_we        = 1'b0;
        tape_waddr     = cell_idx_reg;
        tape_wdata     = tape_rdata;
        stack_we       = 1'b0;
        stack_waddr    = depth_reg[SW-1:0];
        stack_wdata    = pc_reg[CW-1:0];
        stack_raddr    = SW'(depth_reg - 1'b1);
        case (state_reg)
            btm_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        btm_pkg::CMD_LOAD:
                        begin
                            code_we = 1'b1;
                        end
                        btm_pkg::CMD_RESTART:
                        begin
                            cell_idx_next = '0;
                            pc_next       = '0;
                            depth_next    = '0;
                            stop_next     = btm_pkg::ST_EXEC;
                            clr_next      = '0;
                            state_next    = btm_pkg::S_CLEAR;
                        end
                        btm_pkg::CMD_STEP:
                        begin
                            res_next.out_byte = '0;
                            res_next.pc       = pc_reg;
                            if (stop_reg != btm_pkg::ST_EXEC)
                            begin
                                res_next.status = stop_reg;
                                state_next      = btm_pkg::S_DONE;
                            end
                            else if (pc_reg >= len)
                            begin
                                stop_next       = btm_pkg::ST_HALT;
                                res_next.status = btm_pkg::ST_HALT;
                                state_next      = btm_pkg::S_DONE;
                            end
                            else
                            begin
                                state_next = btm_pkg::S_FETCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            btm_pkg::S_CLEAR:
            begin
                tape_we    = 1'b1;
                tape_waddr = clr_reg[TW-1:0];
                tape_wdata = '0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == (TW+1)'(btm_pkg::TAPE_DEPTH - 1))
                begin
                    state_next = btm_pkg::S_IDLE;
                end
            end
            btm_pkg::S_FETCH:
            begin
                // Code byte and current cell arrive next cycle.
                state_next = btm_pkg::S_DECODE;
            end
            btm_pkg::S_DECODE:
            begin
                res_next.status = btm_pkg::ST_EXEC;
                pc_next         = pc_reg + 1'b1;
                state_next      = btm_pkg::S_DONE;
                case (code_rdata)
                    btm_pkg::OP_RIGHT:
                    begin
                        if (cell_idx_reg == TW'(btm_pkg::TAPE_DEPTH - 1))
                        begin
                            stop_next       = btm_pkg::ST_TAPE;
                            res_next.status = btm_pkg::ST_TAPE;
                            pc_next         = pc_reg;
                        end
                        else
                        begin
                            cell_idx_next = cell_idx_reg + 1'b1;
                        end
                    end
                    btm_pkg::OP_LEFT:
                    begin
                        if (cell_idx_reg == '0)
                        begin
                            stop_next       = btm_pkg::ST_UNDER;
                            res_next.status = btm_pkg::ST_UNDER;
                            pc_next         = pc_reg;
                        end
                        else
                        begin
                            cell_idx_next = cell_idx_reg - 1'b1;
                        end
                    end
                    btm_pkg::OP_INC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata + 1'b1;
                    end
                    btm_pkg::OP_DEC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata - 1'b1;
                    end
                    btm_pkg::OP_OUT:
                    begin
                        res_next.status   = btm_pkg::ST_OUT;
                        res_next.out_byte = tape_rdata[7:0];
                    end
                    btm_pkg::OP_IN:
                    begin
                        if (!in_valid_reg)
                        begin
                            res_next.status = btm_pkg::ST_WAIT;
                            pc_next         = pc_reg;
                        end
                        else
                        begin
                            tape_we    = 1'b1;
                            tape_wdata = btm_pkg::CELL_BITS'(in_byte_reg);
                        end
                    end
                    btm_pkg::OP_OPEN:
                    begin
                        if (cell_zero)
                        begin
                            pc_next    = pc_reg;
                            scan_next  = pc_reg + 1'b1;
                            nest_next  = '0;
                            state_next = btm_pkg::S_SKIP_RD;
                        end
                        else if (depth_reg == (SW+1)'(btm_pkg::STACK_DEPTH))
                        begin
                            stop_next       = btm_pkg::ST_STACK;
                            res_next.status = btm_pkg::ST_STACK;
                            pc_next         = pc_reg;
                        end
                        else
                        begin
                            stack_we   = 1'b1;
                            depth_next = depth_reg + 1'b1;
                        end
                    end
                    btm_pkg::OP_CLOSE:
                    begin
                        if (depth_reg == '0)
                        begin
                            stop_next       = btm_pkg::ST_UNCLOSE;
                            res_next.status = btm_pkg::ST_UNCLOSE;
                            pc_next         = pc_reg;
                        end
                        else if (cell_zero)
                        begin
                            depth_next = depth_reg - 1'b1;
                        end
                        else
                        begin
                            pc_next    = pc_reg;
                            state_next = btm_pkg::S_POP_RD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                res_next.pc = pc_next;
            end
            btm_pkg::S_SKIP_RD:
            begin
                // Walk code memory one byte at a time: read here, check in S_SKIP_CHK.
                code_raddr = scan_reg[CW-1:0];
                if (scan_reg >= len)
                begin
                    stop_next       = btm_pkg::ST_UNOPEN;
                    res_next.status = btm_pkg::ST_UNOPEN;
                    res_next.pc     = pc_reg;
                    state_next      = btm_pkg::S_DONE;
                end
                else
                begin
                    state_next = btm_pkg::S_SKIP_CHK;
                end
            end
            btm_pkg::S_SKIP_CHK:
            begin
                state_next = btm_pkg::S_SKIP_RD;
                scan_next  = scan_reg + 1'b1;
                if (code_rdata == btm_pkg::OP_OPEN)
                begin
                    nest_next = nest_reg + 1'b1;
                end
                else if (code_rdata == btm_pkg::OP_CLOSE)
                begin
                    if (nest_reg == '0)
                    begin
                        pc_next         = scan_reg + 1'b1;
                        res_next.status = btm_pkg::ST_EXEC;
                        res_next.pc     = scan_reg + 1'b1;
                        state_next      = btm_pkg::S_DONE;
                    end
                    else
                    begin
                        nest_next = nest_reg - 1'b1;
                    end
                end
            end
            btm_pkg::S_POP_RD:
            begin
                state_next = btm_pkg::S_POP_USE;
            end
            btm_pkg::S_POP_USE:
            begin
                pc_next         = PW'(stack_rdata) + 1'b1;
                res_next.status = btm_pkg::ST_EXEC;
                res_next.pc     = PW'(stack_rdata) + 1'b1;
                state_next      = btm_pkg::S_DONE;
            end
            btm_pkg::S_DONE:
            begin
                res_valid_next = 1'b1;
                state_next     = btm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = btm_pkg::S_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != btm_pkg::S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

FILE: hdl/btm_out.sv
module btm_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  btm_pkg::result_t in_res,
    output logic             full,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata
);

    logic             valid_reg;
    btm_pkg::result_t data_reg;

    // Output register: holds one result until the sink takes the beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= in_res;
        end
    end

    assign full          = valid_reg;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {7'd0, data_reg.pc, data_reg.out_byte, data_reg.status};

endmodule

FILE: hdl/bracket_tape_machine_core.sv
// Steps: a load writes the code byte on the accepted beat, a restart clears the
// tape, a step runs fetch, decode and done to the output register (only done
// when the machine is halted or runs past the end), plus skip read and skip
// check per code byte walked to skip a loop, and pop read and pop use to close one.
// Throughput: one item at a time; the next is taken once the result is out.
// Reset: asynchronous, active low; clears the whole tape first.
module bracket_tape_machine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], code_address[13:2], code_byte[21:14], input_valid[22],
    // input_byte[30:23]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[3:0], output_byte[11:4], program_counter[24:12]
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata
);

    logic [btm_pkg::LEN_W-1:0] program_length_reg;
    logic             busy, res_valid, full, start;
    btm_pkg::result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            program_length_reg <= cfg_wdata;
        end
    end

    // Take a new beat only when idle and no result is pending or held.
    assign s_axis_tready = !busy && !full && !res_valid;
    assign start         = s_axis_tvalid && s_axis_tready;

    btm_seq u_seq (
        .clk(clk), .rst_n(rst_n), .start(start),
        .cmd(s_axis_tdata[1:0]), .code_address(s_axis_tdata[13:2]),
        .code_byte(s_axis_tdata[21:14]), .input_valid(s_axis_tdata[22]),
        .input_byte(s_axis_tdata[30:23]), .program_length(program_length_reg),
        .busy(busy), .res_valid(res_valid), .res(res)
    );

    btm_out u_out (
        .clk(clk), .rst_n(rst_n), .in_valid(res_valid), .in_res(res),
        .full(full), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    // A new result arrives only when the output register is empty or its beat is taken in that cycle.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !full || m_axis_tready)
        else $error("result overran output register");

    // No input beat is taken while the sequencer works.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !s_axis_tready)
        else $error("input accepted while busy");

    // A step beat makes the block busy on the next cycle.
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && s_axis_tdata[1:0] == btm_pkg::CMD_STEP) |=> busy)
        else $error("step did not start the sequencer");

endmodule
